// ----- hdl/compact_size_decoder_defines.svh -----
// Assertion macros shared by the compact size decoder modules.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef COMPACT_SIZE_DECODER_DEFINES_SVH
`define COMPACT_SIZE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/csd_pkg.sv -----
package csd_pkg;

	// Marker bytes that open the two-byte and four-byte forms.
	localparam logic [7:0] MARK_TWO  = 8'd253;
	localparam logic [7:0] MARK_FOUR = 8'd254;

	// Largest byte count of one value, marker included.
	localparam logic [3:0] MAX_USED = 4'd9;

	// Payload byte counts of the three long forms.
	localparam logic [3:0] LEN_TWO   = 4'd2;
	localparam logic [3:0] LEN_FOUR  = 4'd4;
	localparam logic [3:0] LEN_EIGHT = 4'd8;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONCANON = 2'd1,
		ST_TRUNC    = 2'd2
	} csd_status_t;

	typedef enum logic [1:0] {
		FORM_NONE  = 2'd0,
		FORM_TWO   = 2'd1,
		FORM_FOUR  = 2'd2,
		FORM_EIGHT = 2'd3
	} csd_form_t;

	// What the back end does with one queued byte.
	typedef enum logic [1:0] {
		K_SHORT = 2'd0,  // single-byte value, emit it as is
		K_TRUNC = 2'd1,  // input ran out, emit a truncation result
		K_ACC   = 2'd2,  // payload byte, merge into the accumulator
		K_FINAL = 2'd3   // last payload byte, merge and judge the value
	} csd_kind_t;

	typedef struct packed {
		csd_kind_t   kind;
		csd_form_t   form;
		logic [2:0]  lane;   // byte position inside the payload
		logic [3:0]  used;   // bytes consumed so far, marker included
		logic [7:0]  data;
	} csd_cmd_t;

endpackage

// ----- hdl/csd_front.sv -----
module csd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // last_available
	output logic              push,
	output csd_pkg::csd_cmd_t push_cmd,
	input  logic              queue_ready
);
	import csd_pkg::*;

	logic [3:0] rem_q;
	logic [3:0] seen_q;
	csd_form_t  form_q;

	logic       take;
	logic [3:0] rem_d;
	logic [3:0] seen_d;
	csd_form_t  form_d;
	logic [3:0] seen_m1;
	logic [3:0] rem_m1;

	assign s_tready = queue_ready;
	assign take     = s_tvalid && queue_ready;
	assign seen_m1  = seen_q - 4'd1;
	assign rem_m1   = rem_q - 4'd1;

	// Classify the incoming byte and track position within the current value.
	always_comb begin
		rem_d         = rem_q;
		seen_d        = seen_q;
		form_d        = form_q;
		push          = 1'b0;
		push_cmd.kind = K_ACC;
		push_cmd.form = form_q;
		push_cmd.lane = seen_m1[2:0];
		push_cmd.used = seen_q + 4'd1;
		push_cmd.data = s_tdata;
		if (take) begin
			if (rem_q == 4'd0) begin
				push_cmd.lane = 3'd0;
				push_cmd.used = 4'd1;
				if (s_tdata < MARK_TWO) begin
					push          = 1'b1;
					push_cmd.kind = K_SHORT;
				end else begin
					seen_d = 4'd1;
					if (s_tdata == MARK_TWO) begin
						form_d = FORM_TWO;
						rem_d  = LEN_TWO;
					end else if (s_tdata == MARK_FOUR) begin
						form_d = FORM_FOUR;
						rem_d  = LEN_FOUR;
					end else begin
						form_d = FORM_EIGHT;
						rem_d  = LEN_EIGHT;
					end
					push_cmd.form = form_d;
					if (s_tlast) begin
						push          = 1'b1;
						push_cmd.kind = K_TRUNC;
						rem_d         = 4'd0;
						seen_d        = 4'd0;
						form_d        = FORM_NONE;
					end
				end
			end else begin
				push   = 1'b1;
				seen_d = seen_q + 4'd1;
				rem_d  = rem_m1;
				if (rem_m1 == 4'd0) begin
					push_cmd.kind = K_FINAL;
					seen_d        = 4'd0;
					form_d        = FORM_NONE;
				end else if (s_tlast) begin
					push_cmd.kind = K_TRUNC;
					rem_d         = 4'd0;
					seen_d        = 4'd0;
					form_d        = FORM_NONE;
				end else begin
					push_cmd.kind = K_ACC;
				end
			end
		end
	end

	// Position state of the value being parsed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 4'd0;
			seen_q <= 4'd0;
			form_q <= FORM_NONE;
		end else begin
			rem_q  <= rem_d;
			seen_q <= seen_d;
			form_q <= form_d;
		end
	end

endmodule

// ----- hdl/csd_queue.sv -----
`include "compact_size_decoder_defines.svh"

module csd_queue #(
	parameter int Width = 19,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [Width-1:0] pop_data,
	output logic             pop_valid
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [Width-1:0] entry_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];

	// Entry storage; written only, never cleared.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`CSD_ASSERT_SAME(a_q_no_overfill, 1'b1, count_q <= FullCnt, "queue count beyond depth")
	`CSD_ASSERT_SAME(a_q_pop_nonempty, pop, count_q != '0, "queue popped while empty")
	`CSD_ASSERT_SAME(a_q_push_room, push, count_q != FullCnt, "queue written while full")

endmodule

// ----- hdl/csd_back.sv -----
`include "compact_size_decoder_defines.svh"

module csd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  csd_pkg::csd_cmd_t cmd,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       value,
	output csd_pkg::csd_status_t status,
	output logic [3:0]        bytes_used
);
	import csd_pkg::*;

	logic [63:0]  acc_q;
	logic         valid_q;
	logic [63:0]  value_q;
	csd_status_t  status_q;
	logic [3:0]   used_q;

	logic [63:0]  merged;
	logic         bad;
	logic         emit;
	logic [63:0]  res_value;
	csd_status_t  res_status;

	assign pop = cmd_valid && (!valid_q || m_tready);

	// Place the byte in its lane; the first payload byte drops older contents.
	assign merged = ((cmd.lane == 3'd0) ? 64'd0 : acc_q)
		| ({56'd0, cmd.data} << {cmd.lane, 3'b000});

	// A long form carrying a value that a shorter form could hold.
	always_comb begin
		unique case (cmd.form)
			FORM_TWO:  bad = (merged < {56'd0, MARK_TWO});
			FORM_FOUR: bad = (merged[63:16] == 48'd0);
			default:   bad = (merged[63:32] == 32'd0);
		endcase
	end

	// Result decode per entry kind.
	always_comb begin
		emit       = 1'b1;
		res_value  = 64'd0;
		res_status = ST_OK;
		unique case (cmd.kind)
			K_SHORT: res_value = {56'd0, cmd.data};
			K_TRUNC: res_status = ST_TRUNC;
			K_ACC:   emit = 1'b0;
			K_FINAL: begin
				if (bad) begin
					res_status = ST_NONCANON;
				end else begin
					res_value = merged;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	// Accumulator and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= merged;
			if (emit) begin
				value_q  <= res_value;
				status_q <= res_status;
				used_q   <= cmd.used;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= emit;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign bytes_used = used_q;

	`CSD_ASSERT_SAME(a_err_value_zero, valid_q && status_q != ST_OK, value_q == 64'd0,
		"error result carries a nonzero value")
	`CSD_ASSERT_SAME(a_used_range, valid_q, used_q != 4'd0 && used_q <= MAX_USED,
		"byte count out of range")
	`CSD_ASSERT_NEXT(a_acc_silent, pop && cmd.kind == K_ACC && !valid_q, !valid_q,
		"payload byte produced a result")

endmodule

// ----- hdl/compact_size_decoder.sv -----
// Size field decoder: one byte accepted per cycle while the queue has room, limited by the
// single accumulator update in the back end, which takes one queued byte per cycle while
// the output register is empty or being read. A completing byte's result passes through
// a queue entry and then the output register.
// Reset: arst_n clears the parse position, the queue pointers and the output valid flag;
// the accumulator and payload registers are not reset.
module compact_size_decoder #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_available
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] value, [67:64] bytes_used, [71:68] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import csd_pkg::*;

	localparam int CmdW = $bits(csd_cmd_t);

	logic        push;
	logic        queue_ready;
	logic        pop;
	logic        cmd_valid;
	csd_cmd_t    push_cmd;
	csd_cmd_t    pop_cmd;
	logic [CmdW-1:0] pop_bits;
	logic [63:0] value;
	csd_status_t status;
	logic [3:0]  bytes_used;

	// Front end: byte classification and position tracking.
	csd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.push        (push),
		.push_cmd    (push_cmd),
		.queue_ready (queue_ready)
	);

	// Queue between front and back ends.
	csd_queue #(
		.Width (CmdW),
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_cmd),
		.push_ready (queue_ready),
		.pop        (pop),
		.pop_data   (pop_bits),
		.pop_valid  (cmd_valid)
	);

	assign pop_cmd = csd_cmd_t'(pop_bits);

	// Back end: accumulation, canonical check and output register.
	csd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (pop_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.value      (value),
		.status     (status),
		.bytes_used (bytes_used)
	);

	assign m_tdata = {4'd0, bytes_used, value};
	assign m_tuser = status;

endmodule
